@@ design/modular_exponentiation_assert.svh @@
// assertion macros shared by the modular exponentiation modules
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// property checked every cycle outside reset
`define MEX_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MEX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/modexp_pkg.sv @@
// shared types and constants for the modular exponentiation block
package modexp_pkg;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam logic [0:0] REG_MODULUS = 1'b0;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_PREP   = 6'b000100,
    S_BIT    = 6'b001000,
    S_ROUND  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic y_one;
    logic round;
    logic shift;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_exp_zero;
    logic exp_last;
  } dp_status_t;

endpackage

@@ design/modular_exponentiation.sv @@
// a zero exponent goes straight to the finish state; otherwise the base is first reduced
// below the modulus, then one serial multiply/square pass runs per exponent bit, up to
// EXPONENT_WIDTH passes, one operand bit a cycle
// one transaction in flight; next input taken once the result is in the output register
// synchronous active-high reset: controller idle, output empty, modulus 1000000007
module modular_exponentiation #(
  parameter int OPERAND_WIDTH  = 31,
  parameter int EXPONENT_WIDTH = 63
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [OPERAND_WIDTH-1:0]              base_value,
  input  logic [EXPONENT_WIDTH-1:0]             exponent,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [OPERAND_WIDTH-1:0]              power_result,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [modexp_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [modexp_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [modexp_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                  pready
);
  import modexp_pkg::*;

  logic [OPERAND_WIDTH-1:0] modulus;
  logic                     reg_sel;
  dp_cmd_t                  cmd;
  dp_status_t               status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_WIDTH-1:2] == REG_MODULUS);
  assign prdata  = reg_sel ? APB_DATA_WIDTH'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= OPERAND_WIDTH'(MODULUS_RESET);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      modulus <= pwdata[OPERAND_WIDTH-1:0];
    end
  end

  modexp_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  modexp_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .EXPONENT_WIDTH(EXPONENT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .base_value  (base_value),
    .exponent    (exponent),
    .modulus     (modulus),
    .power_result(power_result)
  );

endmodule

@@ design/modexp_dp.sv @@
// datapath: exponent shifter, accumulator, square and two serial modular multiplier lanes
`include "modular_exponentiation_assert.svh"

module modexp_dp #(
  parameter int OPERAND_WIDTH  = 31,
  parameter int EXPONENT_WIDTH = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  modexp_pkg::dp_cmd_t       cmd,
  output modexp_pkg::dp_status_t    status,
  input  logic [OPERAND_WIDTH-1:0]  base_value,
  input  logic [EXPONENT_WIDTH-1:0] exponent,
  input  logic [OPERAND_WIDTH-1:0]  modulus,
  output logic [OPERAND_WIDTH-1:0]  power_result
);
  import modexp_pkg::*;

  localparam int TW = OPERAND_WIDTH + 2;

  logic [OPERAND_WIDTH-1:0]  acc;
  logic [OPERAND_WIDTH-1:0]  sq;
  logic [OPERAND_WIDTH-1:0]  xa;
  logic [OPERAND_WIDTH-1:0]  xs;
  logic [OPERAND_WIDTH-1:0]  ra;
  logic [OPERAND_WIDTH-1:0]  rs;
  logic [EXPONENT_WIDTH-1:0] exp_reg;
  logic [OPERAND_WIDTH-1:0]  result;

  logic [TW-1:0]            m1;
  logic [TW-1:0]            m2;
  logic [OPERAND_WIDTH-1:0] ys;
  logic [TW-1:0]            ta;
  logic [TW-1:0]            ts;
  logic [OPERAND_WIDTH-1:0] ra_next;
  logic [OPERAND_WIDTH-1:0] rs_next;
  logic                     mod_zero;
  logic                     acc_take;

  assign m1       = {2'b00, modulus};
  assign m2       = {1'b0, modulus, 1'b0};
  assign mod_zero = (modulus == '0);
  assign ys       = cmd.y_one ? OPERAND_WIDTH'(1) : sq;
  assign ta       = {1'b0, ra, 1'b0} + (xa[OPERAND_WIDTH-1] ? {2'b00, sq} : TW'(0));
  assign ts       = {1'b0, rs, 1'b0} + (xs[OPERAND_WIDTH-1] ? {2'b00, ys} : TW'(0));
  assign acc_take = cmd.shift && exp_reg[0];

  // double, add, then bring back below the modulus (no reduction when the modulus is zero)
  always_comb begin
    if (mod_zero) begin
      ra_next = ta[OPERAND_WIDTH-1:0];
    end else if (ta >= m2) begin
      ra_next = OPERAND_WIDTH'(ta - m2);
    end else if (ta >= m1) begin
      ra_next = OPERAND_WIDTH'(ta - m1);
    end else begin
      ra_next = ta[OPERAND_WIDTH-1:0];
    end
  end

  always_comb begin
    if (mod_zero) begin
      rs_next = ts[OPERAND_WIDTH-1:0];
    end else if (ts >= m2) begin
      rs_next = OPERAND_WIDTH'(ts - m2);
    end else if (ts >= m1) begin
      rs_next = OPERAND_WIDTH'(ts - m1);
    end else begin
      rs_next = ts[OPERAND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc     <= OPERAND_WIDTH'(1);
      exp_reg <= exponent;
      xa      <= '0;
      xs      <= base_value;
      ra      <= '0;
      rs      <= '0;
    end else if (cmd.step) begin
      ra <= ra_next;
      rs <= rs_next;
      xa <= {xa[OPERAND_WIDTH-2:0], 1'b0};
      xs <= {xs[OPERAND_WIDTH-2:0], 1'b0};
    end else if (cmd.round) begin
      sq <= rs;
      if (acc_take) begin
        acc <= ra;
      end
      if (cmd.shift) begin
        exp_reg <= {1'b0, exp_reg[EXPONENT_WIDTH-1:1]};
      end
      xa <= acc_take ? ra : acc;
      xs <= rs;
      ra <= '0;
      rs <= '0;
    end
    if (cmd.emit) begin
      result <= acc;
    end
  end

  assign status.in_exp_zero = (exponent == '0);
  assign status.exp_last    = (exp_reg[EXPONENT_WIDTH-1:1] == '0);
  assign power_result       = result;

  `MEX_ASSERT(a_cmd_exclusive, clk, rst, $onehot0({cmd.load, cmd.step, cmd.round}), "datapath commands overlap")
  `MEX_ASSERT_NEXT(a_square_lane_reduced, clk, rst, cmd.step && !mod_zero, rs < $past(modulus), "square lane left range")
  `MEX_ASSERT_NEXT(a_acc_lane_reduced, clk, rst, cmd.step && !cmd.y_one && !mod_zero, ra < $past(modulus), "multiply lane left range")

endmodule

@@ design/modexp_ctrl.sv @@
// controller: sequences base reduction, per-bit multiply and square, and result hand-off
`include "modular_exponentiation_assert.svh"

module modexp_ctrl #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output modexp_pkg::dp_cmd_t    cmd,
  input  modexp_pkg::dp_status_t status
);
  import modexp_pkg::*;

  localparam int CW = $clog2(OPERAND_WIDTH);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          last;
  logic          out_valid_next;

  assign last = (cnt == CW'(OPERAND_WIDTH - 1));

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_exp_zero ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.step  = 1'b1;
        cmd.y_one = 1'b1;
        if (last) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.round  = 1'b1;
        state_next = S_BIT;
      end
      S_BIT: begin
        cmd.step = 1'b1;
        if (last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        cmd.shift  = 1'b1;
        state_next = status.exp_last ? S_FINISH : S_BIT;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign cnt_next = (cmd.step && !last) ? cnt + CW'(1) : '0;

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `MEX_ASSERT(a_cnt_range, clk, rst, cnt <= CW'(OPERAND_WIDTH - 1), "step counter overran")
  `MEX_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted while busy")
  `MEX_ASSERT(a_emit_from_finish, clk, rst, $rose(out_valid) |-> $past(state == S_FINISH), "result without finish")

endmodule

@@ tb/sv/tb.sv @@
// testbench for modular_exponentiation: directed table then random phases, scoreboard check
module tb;
  import modexp_pkg::*;

  localparam int OW = 31;
  localparam int EW = 63;
  localparam logic [2:0] ADDR_MODULUS = {2'b00, REG_MODULUS} << 2;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam logic [OW-1:0] MAXB = '1;
  localparam logic [EW-1:0] MAXE = '1;
  localparam int N_ROWS = 25;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 34;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [2:0]    addr;
    logic [31:0]   data;
    logic [OW-1:0] base;
    logic [EW-1:0] expo;
    logic          typed;
    logic [OW-1:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [OW-1:0] base_value, power_result;
  logic [EW-1:0] exponent;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata, prdata;

  logic typed_valid;
  logic [OW-1:0] typed_value;
  logic [OW-1:0] modulus_model;
  logic [OW-1:0] power_q[$];
  logic [OW-1:0] want_power;
  int err_count = 0;
  bit no_stall = 1'b0;
  stim_row_t dir_rows[N_ROWS];

  modular_exponentiation #(
    .OPERAND_WIDTH (OW),
    .EXPONENT_WIDTH(EW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base_value  (base_value),
    .exponent    (exponent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .power_result(power_result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                         input logic [OW-1:0] m);
    logic [63:0] p;
    p = a * b;
    if (m == '0) return p & 64'h7FFF_FFFF;
    return p % {33'd0, m};
  endfunction

  function automatic logic [OW-1:0] modpow(input logic [OW-1:0] b, input logic [EW-1:0] e,
                                           input logic [OW-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [EW-1:0] rest;
    acc = 64'd1;
    sq = {33'd0, b};
    rest = e;
    while (rest != '0) begin
      if (rest[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      rest = rest >> 1;
    end
    return acc[OW-1:0];
  endfunction

  function automatic void report_err(input string what, input logic [63:0] want,
                                     input logic [63:0] got);
    err_count++;
    if (err_count <= 10)
      $display("mismatch %0s: expected %0d got %0d at %0t", what, want, got, $realtime);
  endfunction

  // accepted input transaction
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      power_q = {power_q,
                 (typed_valid ? typed_value : modpow(base_value, exponent, modulus_model))};
  end

  // accepted output transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (power_q.size() == 0) begin
        report_err("unexpected power_result", 64'd0, {33'd0, power_result});
      end else begin
        want_power = power_q.pop_front();
        if (power_result !== want_power)
          report_err("power_result", {33'd0, want_power}, {33'd0, power_result});
      end
    end
  end

  initial begin
    int n;
    out_ready <= 1'b0;
    wait (!rst);
    forever begin
      n = no_stall ? 0 : $urandom_range(0, 10);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(input logic [OW-1:0] b, input logic [EW-1:0] e, input logic typed,
                           input logic [OW-1:0] want);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    base_value <= b;
    exponent <= e;
    typed_valid <= typed;
    typed_value <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (power_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_modulus_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MODULUS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {1'b0, modulus_model})
      report_err("modulus readback", {33'd0, modulus_model}, {32'd0, prdata});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] addr, input logic [31:0] data);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MODULUS) modulus_model = data[OW-1:0];
    @(posedge clk);
    check_modulus_readback();
  endtask

  initial begin
    logic [63:0] r;
    logic [63:0] mask;
    logic [OW-1:0] b;
    logic [EW-1:0] e;
    logic [31:0] wdata;
    int len;

    in_valid <= 1'b0;
    base_value <= '0;
    exponent <= '0;
    typed_valid <= 1'b0;
    typed_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    modulus_model = MODULUS_RESET[OW-1:0];

    dir_rows = '{
      '{ROW_ITEM,  3'd0, 32'd0, 31'd0, 63'd0, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, 63'd0, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd0, 63'd1, 1'b1, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd2, 63'd10, 1'b1, 31'd1024},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd1, MAXE, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd0, MAXE, 1'b1, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, 63'd1, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, MAXE, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd1000000007, 63'd1, 1'b1, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd1000000008, 63'd1, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd12345, 63'h4000_0000_0000_0000, 1'b0, 31'd0},
      '{ROW_WRITE, ADDR_MODULUS, 32'd1, 31'd0, 63'd0, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd5, 63'd0, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd5, 63'd3, 1'b1, 31'd0},
      '{ROW_WRITE, ADDR_MODULUS, 32'd0, 31'd0, 63'd0, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd2, 63'd31, 1'b1, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd3, 63'd2, 1'b1, 31'd9},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, 63'd2, 1'b1, 31'd1},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, MAXE, 1'b0, 31'd0},
      '{ROW_WRITE, ADDR_MODULUS, 32'hFFFF_FFFF, 31'd0, 63'd0, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, MAXB, 63'd1, 1'b1, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd2, 63'd31, 1'b1, 31'd1},
      '{ROW_WRITE, ADDR_UNMAPPED, 32'd7, 31'd0, 63'd0, 1'b0, 31'd0},
      '{ROW_ITEM,  3'd0, 32'd0, 31'd2, 63'd30, 1'b1, 31'h4000_0000},
      '{ROW_WRITE, ADDR_MODULUS, 32'd1000000007, 31'd0, 63'd0, 1'b0, 31'd0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_modulus_readback();

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        configure(dir_rows[i].addr, dir_rows[i].data);
      else
        send_item(dir_rows[i].base, dir_rows[i].expo, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: wdata = $urandom;
        1: wdata = $urandom_range(1, 255);
        2: wdata = MODULUS_RESET;
        3: wdata = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
        4: wdata = 32'd0;
        5: wdata = 32'd1;
        6: wdata = $urandom & 32'h7FFF_FFFF;
        default: wdata = $urandom | 32'h8000_0000;
      endcase
      configure(ADDR_MODULUS, wdata);
      no_stall = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 29) == 0) wait_idle();
        case ($urandom_range(0, 3))
          0: b = OW'($urandom_range(0, 15));
          1: b = modulus_model + OW'($urandom_range(0, 2));
          2: b = $urandom_range(0, 1) ? MAXB : '0;
          default: b = OW'($urandom);
        endcase
        r = {$urandom, $urandom};
        len = $urandom_range(0, 3) == 0 ? EW : $urandom_range(0, EW);
        if (len == 0) begin
          e = '0;
        end else begin
          mask = (64'd1 << len) - 64'd1;
          e = EW'((r & mask) | (64'd1 << (len - 1)));
        end
        send_item(b, e, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (err_count == 0 && power_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/modexp_pkg.sv
design/modexp_dp.sv
design/modexp_ctrl.sv
design/modular_exponentiation.sv
tb/sv/tb.sv
